### sv/ptc_pkg.sv
// Package: payload types, register indexes and constants for pressure/temperature compensation.
`default_nettype none
package ptc_pkg;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] fine_temperature;
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_pa;
    logic               divide_by_zero;
  } out_beat_t;

  // Work handed from the front part to the divider/back part.
  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] temp;
    logic [31:0] dividend;
    logic [31:0] divisor;
    logic        div_first;
  } job_t;

  localparam logic [1:0] RegCalibT  = 2'd0;
  localparam logic [1:0] RegCalibPl = 2'd1;
  localparam logic [1:0] RegCalibPh = 2'd2;
  localparam logic [1:0] RegCalibP9 = 2'd3;

  localparam logic [31:0] Offset64k = 32'd64000;
  localparam logic [31:0] Scale1M   = 32'd1048576;
  localparam logic [31:0] Mul3125   = 32'd3125;
  localparam logic [31:0] Sign32    = 32'h8000_0000;
  localparam logic [31:0] Half32k   = 32'd32768;
  localparam logic [31:0] Round128  = 32'd128;

  function automatic logic [31:0] mulw(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

### sv/ptc_front.sv
// Front pipeline: temperature terms and pressure dividend/divisor.
`default_nettype none
module ptc_front import ptc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire logic        in_fire,
  input  wire in_beat_t    in_beat,
  input  wire logic [47:0] calib_t,
  input  wire logic [63:0] calib_pl,
  input  wire logic [31:0] calib_ph_lo,
  output logic             job_valid,
  output job_t             job
);
  localparam int Stages = 7;
  logic [Stages-1:0] vld;

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
  assign t1 = {16'd0, calib_t[15:0]};
  assign t2 = sx16(calib_t[31:16]);
  assign t3 = sx16(calib_t[47:32]);
  assign p1 = {16'd0, calib_pl[15:0]};
  assign p2 = sx16(calib_pl[31:16]);
  assign p3 = sx16(calib_pl[47:32]);
  assign p4 = sx16(calib_pl[63:48]);

  // p5/p6 come from the low word of the high calibration register
  assign p5 = sx16(calib_ph_lo[15:0]);
  assign p6 = sx16(calib_ph_lo[31:16]);

  // Stage 1
  logic [31:0] s1_ta, s1_d, s1_adcp;
  // Stage 2
  logic [31:0] s2_a, s2_dd, s2_adcp;
  // Stage 3
  logic [31:0] s3_a, s3_b, s3_adcp;
  // Stage 4
  logic [31:0] s4_fine, s4_temp5, s4_pa, s4_adcp;
  // Stage 5
  logic [31:0] s5_fine, s5_temp, s5_q, s5_pa5, s5_pa2, s5_adcp;
  // Stage 6
  logic [31:0] s6_fine, s6_temp, s6_b, s6_a, s6_adcp;
  // Stage 7
  logic [31:0] s7_fine, s7_temp, s7_x, s7_pres;

  logic [31:0] s6_bsum, s6_asum, s7_b2, s7_base;
  always_comb begin
    s6_bsum = asr(mulw(asr(s5_q, 11), p6) + (s5_pa5 << 1), 2) + (p4 << 16);
    s6_asum = asr(asr(mulw(p3, asr(s5_q, 13)), 3) + asr(s5_pa2, 1), 18);
    s7_b2   = Half32k + s6_a;
    s7_base = (Scale1M - s6_adcp) - asr(s6_b, 12);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[Stages-2:0], in_fire};
    end
    if (advance) begin
      s1_ta   <= ({12'd0, in_beat.raw_temperature} >> 3) - (t1 << 1);
      s1_d    <= ({12'd0, in_beat.raw_temperature} >> 4) - t1;
      s1_adcp <= {12'd0, in_beat.raw_pressure};
      s2_a    <= asr(mulw(s1_ta, t2), 11);
      s2_dd   <= asr(mulw(s1_d, s1_d), 12);
      s2_adcp <= s1_adcp;
      s3_a    <= s2_a;
      s3_b    <= asr(mulw(s2_dd, t3), 14);
      s3_adcp <= s2_adcp;
      s4_fine  <= s3_a + s3_b;
      s4_temp5 <= mulw(s3_a + s3_b, 32'd5);
      s4_pa    <= asr(s3_a + s3_b, 1) - Offset64k;
      s4_adcp  <= s3_adcp;
      s5_fine <= s4_fine;
      s5_temp <= asr(s4_temp5 + Round128, 8);
      s5_q    <= mulw(asr(s4_pa, 2), asr(s4_pa, 2));
      s5_pa5  <= mulw(s4_pa, p5);
      s5_pa2  <= mulw(p2, s4_pa);
      s5_adcp <= s4_adcp;
      s6_fine <= s5_fine;
      s6_temp <= s5_temp;
      s6_b    <= s6_bsum;
      s6_a    <= s6_asum;
      s6_adcp <= s5_adcp;
      s7_fine <= s6_fine;
      s7_temp <= s6_temp;
      s7_x    <= asr(mulw(s7_b2, p1), 15);
      s7_pres <= mulw(s7_base, Mul3125);
    end
  end

  assign job_valid     = vld[Stages-1];
  assign job.fine      = s7_fine;
  assign job.temp      = s7_temp;
  assign job.divisor   = s7_x;
  assign job.div_first = (s7_pres >= Sign32);
  assign job.dividend  = (s7_pres >= Sign32) ? s7_pres : (s7_pres << 1);
endmodule
`default_nettype wire

### sv/ptc_queue.sv
// Short FIFO between front and back parts.
`default_nettype none
module ptc_queue import ptc_pkg::*; #(
  parameter int Depth = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_data,
  input  wire logic pop,
  output logic      not_empty,
  output logic [$clog2(Depth+1)-1:0] count,
  output job_t      pop_data
);
  localparam int Aw = $clog2(Depth);
  job_t mem [Depth];
  logic [Aw-1:0] wp, rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == Aw'(Depth-1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == Aw'(Depth-1)) ? '0 : rp + 1'b1;
      count <= count + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
    if (push) mem[wp] <= push_data;
  end
  assign not_empty = (count != '0);
  assign pop_data  = mem[rp];
endmodule
`default_nettype wire

### sv/ptc_back.sv
// Back part: pipelined radix-2 divider and final pressure correction.
`default_nettype none
module ptc_back import ptc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire logic        in_valid,
  input  wire job_t        job,
  input  wire logic [63:0] calib_ph,
  input  wire logic [15:0] calib_p9,
  output logic             out_valid,
  output out_beat_t        out_beat
);
  // Restoring division, four quotient bits per stage over eight stages.
  localparam int DivStages = 8;
  localparam int BitsPer   = 4;
  localparam int Tail      = 3;
  localparam int Total     = DivStages + Tail;

  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] temp;
    logic [31:0] num;
    logic [31:0] rem;
    logic [31:0] den;
    logic        dbl;
    logic        zero;
  } dstage_t;

  dstage_t ds [DivStages+1];
  dstage_t dn [DivStages];
  logic [Total-1:0] vld;

  always_comb begin
    ds[0].fine = job.fine;
    ds[0].temp = job.temp;
    ds[0].num  = job.dividend;
    ds[0].rem  = '0;
    ds[0].den  = job.divisor;
    ds[0].dbl  = job.div_first;
    ds[0].zero = (job.divisor == '0);
  end

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    always_comb begin
      logic [32:0] r;
      dn[g] = ds[g];
      for (int k = 0; k < BitsPer; k++) begin
        r = {dn[g].rem, dn[g].num[31]};
        dn[g].num = dn[g].num << 1;
        if (r >= {1'b0, dn[g].den}) begin
          r = r - {1'b0, dn[g].den};
          dn[g].num[0] = 1'b1;
        end
        dn[g].rem = r[31:0];
      end
    end
    always_ff @(posedge clk) begin
      if (advance) ds[g+1] <= dn[g];
    end
  end

  logic [31:0] p7, p8, p9;
  assign p7 = sx16(calib_ph[47:32]);
  assign p8 = sx16(calib_ph[63:48]);
  assign p9 = sx16(calib_p9);

  logic [31:0] t1_fine, t1_temp, t1_pres, t2_fine, t2_temp, t2_pres, t2_q, t2_b;
  logic [31:0] t3_fine, t3_temp, t3_pres;
  logic        t1_zero, t2_zero, t3_zero;
  logic [31:0] quo;
  assign quo = ds[DivStages].dbl ? (ds[DivStages].num << 1) : ds[DivStages].num;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[Total-2:0], in_valid};
    end
    if (advance) begin
      t1_fine <= ds[DivStages].fine;
      t1_temp <= ds[DivStages].temp;
      t1_zero <= ds[DivStages].zero;
      t1_pres <= quo;
      t2_fine <= t1_fine;
      t2_temp <= t1_temp;
      t2_zero <= t1_zero;
      t2_pres <= t1_pres;
      t2_q    <= mulw(t1_pres >> 3, t1_pres >> 3) >> 13;
      t2_b    <= asr(mulw(t1_pres >> 2, p8), 13);
      t3_fine <= t2_fine;
      t3_temp <= t2_temp;
      t3_zero <= t2_zero;
      t3_pres <= t2_zero ? '0
                 : t2_pres + asr(asr(mulw(p9, t2_q), 12) + t2_b + p7, 4);
    end
  end

  assign out_valid                  = vld[Total-1];
  assign out_beat.fine_temperature  = t3_fine;
  assign out_beat.temperature_centi = t3_temp;
  assign out_beat.pressure_pa       = t3_pres;
  assign out_beat.divide_by_zero    = t3_zero;
endmodule
`default_nettype wire

### sv/pressure_temp_compensation.sv
// Top level: APB calibration registers, front pipeline, job queue, divider back part.
// Path: the input beat passes the 7 front stages, one queue write and the 11 back stages
// before its result is valid.
// Throughput: one beat per cycle while the output side takes results.
// Back pressure stalls the back pipeline; the queue absorbs the front's in-flight beats.
// Reset (rst, synchronous) empties pipelines and queue and clears calibration to zero.
`default_nettype none
module pressure_temp_compensation import ptc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_beat_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_beat_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  // Queue must hold every beat in flight in the front pipeline plus a margin.
  localparam int QDepth = 16;

  logic [47:0] calib_t;
  logic [63:0] calib_pl, calib_ph;
  logic [15:0] calib_p9;
  logic [1:0]  ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:3];

  // Write registers at the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_t <= '0;
      calib_pl <= '0;
      calib_ph <= '0;
      calib_p9 <= '0;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      case (ridx)
        RegCalibT:  calib_t  <= pwdata[47:0];
        RegCalibPl: calib_pl <= pwdata;
        RegCalibPh: calib_ph <= pwdata;
        RegCalibP9: calib_p9 <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      RegCalibT:  prdata = {16'd0, calib_t};
      RegCalibPl: prdata = calib_pl;
      RegCalibPh: prdata = calib_ph;
      RegCalibP9: prdata = {48'd0, calib_p9};
      default:    prdata = '0;
    endcase
  end

  // Front pipeline runs freely; admission is gated by queue room.
  logic job_valid, q_ne, q_pop, back_adv, in_fire;
  job_t job, q_job;
  logic [$clog2(QDepth+1)-1:0] q_count;
  logic [$clog2(QDepth+1)-1:0] inflight;

  ptc_front u_front (
    .clk, .rst, .advance(1'b1), .in_fire, .in_beat(in_data),
    .calib_t, .calib_pl, .calib_ph_lo(calib_ph[31:0]), .job_valid, .job
  );

  // Count beats in the front pipeline to reserve queue room.
  always_ff @(posedge clk) begin
    if (rst) inflight <= '0;
    else inflight <= inflight + (in_fire ? 1'b1 : 1'b0) - (job_valid ? 1'b1 : 1'b0);
  end

  assign in_ready = (32'(q_count) + 32'(inflight)) < (QDepth - 1);
  assign in_fire  = in_valid && in_ready;

  ptc_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst, .push(job_valid), .push_data(job), .pop(q_pop),
    .not_empty(q_ne), .count(q_count), .pop_data(q_job)
  );

  // Back part advances when its output slot is empty or being taken.
  assign back_adv = !out_valid || out_ready;
  assign q_pop    = back_adv && q_ne;

  ptc_back u_back (
    .clk, .rst, .advance(back_adv), .in_valid(q_pop), .job(q_job),
    .calib_ph, .calib_p9, .out_valid, .out_beat(out_data)
  );
endmodule
`default_nettype wire

### verif/pressure_temp_compensation_checker.sv
// Checker: watches both channels, predicts each compensated sample and compares.
`timescale 1ns / 100ps
module pressure_temp_compensation_checker import ptc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_ready,
  input  wire in_beat_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_ready,
  input  wire out_beat_t out_data,
  input  wire logic      psel,
  input  wire logic      penable,
  input  wire logic      pwrite,
  input  wire logic      pready,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output int             errors,
  output int             pending
);

  logic [47:0] cal_t;
  logic [63:0] cal_pl, cal_ph;
  logic [15:0] cal_p9;
  out_beat_t   expected_q[$];

  function automatic logic [31:0] sra(logic [31:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] m32(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  function automatic logic [31:0] s16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic out_beat_t compensate(in_beat_t s);
    logic [31:0] at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, q, fine, pres;
    out_beat_t r;
    at = {12'd0, s.raw_temperature};
    ap = {12'd0, s.raw_pressure};
    t1 = {16'd0, cal_t[15:0]};  t2 = s16(cal_t[31:16]);  t3 = s16(cal_t[47:32]);
    p1 = {16'd0, cal_pl[15:0]}; p2 = s16(cal_pl[31:16]); p3 = s16(cal_pl[47:32]);
    p4 = s16(cal_pl[63:48]);    p5 = s16(cal_ph[15:0]);  p6 = s16(cal_ph[31:16]);
    p7 = s16(cal_ph[47:32]);    p8 = s16(cal_ph[63:48]); p9 = s16(cal_p9);
    a = sra(m32((at >> 3) - (t1 << 1), t2), 11);
    d = (at >> 4) - t1;
    b = sra(m32(sra(m32(d, d), 12), t3), 14);
    fine = a + b;
    r.fine_temperature  = fine;
    r.temperature_centi = sra(m32(fine, 32'd5) + 32'd128, 8);
    a = sra(fine, 1) - 32'd64000;
    q = m32(sra(a, 2), sra(a, 2));
    b = m32(sra(q, 11), p6) + (m32(a, p5) << 1);
    b = sra(b, 2) + (p4 << 16);
    a = sra(sra(m32(p3, sra(q, 13)), 3) + sra(m32(p2, a), 1), 18);
    a = sra(m32(32'd32768 + a, p1), 15);
    pres = m32((32'd1048576 - ap) - sra(b, 12), 32'd3125);
    r.divide_by_zero = (a == 0);
    if (a == 0) begin
      pres = 0;
    end else begin
      // small dividends double first, large ones divide first
      if (pres < 32'h8000_0000) pres = (pres << 1) / a;
      else pres = (pres / a) * 32'd2;
      q = m32(pres >> 3, pres >> 3) >> 13;
      a = sra(m32(p9, q), 12);
      b = sra(m32(pres >> 2, p8), 13);
      pres = pres + sra(a + b + p7, 4);
    end
    r.pressure_pa = pres;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  assign pending = expected_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    out_beat_t e;
    if (rst) begin
      cal_t <= '0; cal_pl <= '0; cal_ph <= '0; cal_p9 <= '0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          RegCalibT:  cal_t  <= pwdata[47:0];
          RegCalibPl: cal_pl <= pwdata;
          RegCalibPh: cal_ph <= pwdata;
          RegCalibP9: cal_p9 <= pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_q.push_back(compensate(in_data));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("unexpected result beat at %0t", $realtime);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_data.fine_temperature !== e.fine_temperature)
            report("fine_temperature", out_data.fine_temperature, e.fine_temperature);
          if (out_data.temperature_centi !== e.temperature_centi)
            report("temperature_centi", out_data.temperature_centi, e.temperature_centi);
          if (out_data.pressure_pa !== e.pressure_pa)
            report("pressure_pa", out_data.pressure_pa, e.pressure_pa);
          if (out_data.divide_by_zero !== e.divide_by_zero)
            report("divide_by_zero", out_data.divide_by_zero, e.divide_by_zero);
        end
      end
    end
  end

endmodule

### verif/pressure_temp_compensation_test.sv
// Testbench top: clock, reset, calibration writes, sample stimulus and verdict.
`timescale 1ns / 100ps
module pressure_temp_compensation_test;
  import ptc_pkg::*;

  localparam int CycleLimit = 200000;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  out_beat_t   out_data;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  int          errors, pending;
  int          cycles = 0;
  int          hold_off = 0;   // cycles left in the long receiver stall
  bit          long_stall_req = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  pressure_temp_compensation i_dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pressure_temp_compensation_checker i_checker (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .errors, .pending
  );

  // Watchdog: any hang ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stall pattern, with quiet stretches, plus one long hold-off
  // so the pipeline and queue fill up and in_ready drops.
  always @(posedge clk) begin
    int mode;
    if (rst) begin
      out_ready <= 0;
      mode = 0;
    end else if (long_stall_req && hold_off == 0) begin
      hold_off <= 300;
      out_ready <= 0;
    end else if (hold_off > 1) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else begin
      if (hold_off == 1) hold_off <= 0;
      mode = (cycles / 400) % 3;
      if (mode == 0) out_ready <= 1;
      else if (mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= ($urandom_range(0, 1) != 0);
    end
  end

  // Write one calibration register: setup cycle, access cycle, then an idle cycle.
  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic set_calib(logic [47:0] t, logic [63:0] pl, logic [63:0] ph, logic [15:0] p9);
    write_reg(RegCalibT, {16'd0, t});
    write_reg(RegCalibPl, pl);
    write_reg(RegCalibPh, ph);
    write_reg(RegCalibP9, {48'd0, p9});
  endtask

  // Offer one beat; hold valid and payload until accepted.
  task automatic send(logic [19:0] rt, logic [19:0] rp);
    in_valid <= 1;
    in_data  <= '{raw_temperature: rt, raw_pressure: rp};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Bursts of back-to-back beats, random gaps between them.
  task automatic send_random(int count, bit typical);
    int left, burst;
    logic [19:0] rt, rp;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && left > 0; k++) begin
        if (typical) begin
          rt = 20'($urandom_range(400000, 600000));
          rp = 20'($urandom_range(250000, 450000));
        end else begin
          rt = 20'($urandom);
          rp = 20'($urandom);
        end
        send(rt, rp);
        left--;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_valid <= 0;
  endtask

  // Let every expected beat drain, then let the pipeline settle.
  task automatic drain;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Typical datasheet-like calibration with random jitter.
  task automatic typical_calib;
    set_calib({16'(-1000 + $urandom_range(0, 2000)), 16'(26000 + $urandom_range(0, 2000)),
               16'(27000 + $urandom_range(0, 2000))},
              {16'(2800 + $urandom_range(0, 200)), 16'(-4200 + $urandom_range(0, 400)),
               16'(-10600 + $urandom_range(0, 400)), 16'(36000 + $urandom_range(0, 2000))},
              {16'(-7 + $urandom_range(0, 14)), 16'(15500 + $urandom_range(0, 100)),
               16'(-2950 + $urandom_range(0, 100)), 16'(150 + $urandom_range(0, 20))},
              16'(6000 + $urandom_range(0, 200)));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reset calibration is all zero: every divisor is zero.
    send(20'd0, 20'd0);
    send(20'hFFFFF, 20'hFFFFF);
    in_valid <= 0;
    drain();

    // Typical calibration, extremes of both raw fields.
    set_calib({16'd50, 16'd26435, 16'd27504}, {16'd3024, 16'hD67E, 16'hD0F5, 16'd36477},
              {16'hFFF9, 16'd15500, 16'hF384, 16'd140}, 16'd6000);
    send(20'd0, 20'd0);
    send(20'hFFFFF, 20'd0);
    send(20'd0, 20'hFFFFF);
    send(20'hFFFFF, 20'hFFFFF);
    send(20'd519888, 20'd415148);
    send(20'h55555, 20'hAAAAA);
    send(20'hAAAAA, 20'h55555);
    // Large dividend: low raw pressure pushes it past the sign bit.
    send(20'd519888, 20'd1);
    send(20'd519888, 20'd100000);
    in_valid <= 0;
    drain();

    // Extreme calibration: all ones, then mins/maxes of signed fields.
    set_calib('1, '1, '1, 16'hFFFF);
    send(20'd0, 20'd0); send(20'hFFFFF, 20'hFFFFF); send(20'h12345, 20'h6789A);
    in_valid <= 0;
    drain();
    set_calib({16'h8000, 16'h7FFF, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF},
              {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h8000);
    send(20'd0, 20'hFFFFF); send(20'hFFFFF, 20'd0); send(20'h80000, 20'h80000);
    in_valid <= 0;
    drain();

    // Random phases: mostly typical calibration, some fully random.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 3 == 2)
        set_calib(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                  16'($urandom));
      else
        typical_calib();
      if (ph == 1) long_stall_req = 1;
      send_random(50, 1);
      long_stall_req = 0;
      send_random(25, ph % 3 == 2 ? 1'b0 : 1'b1);
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
